// ===== hdl/lads_pkg.sv =====
package lads_pkg;

    localparam int DEPTH  = 8;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_REAR  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_REAR   = 3'd3,
        ACT_TRAVERSE   = 3'd4,
        ACT_SEARCH     = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_NOTFOUND  = 2'd3
    } t_status;

    // array index reported modulo eight
    function automatic logic [2:0] to_slot(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+2:0] ext;
        ext = {3'b000, idx};
        return ext[2:0];
    endfunction

endpackage

// ===== hdl/linear_array_deque_with_search_core.sv =====
// Deque of signed 32-bit words held in a non-wrapping array memory with one write
// and one registered read port. A command is taken when start is high and busy is
// low; each result appears for one cycle with o_valid high and must be captured
// then, as there is no way to hold it off. Pushes, overflows and empty-store answers
// come in the cycle after the command with busy staying low, so such commands can be
// issued every cycle. A pop keeps busy high for one cycle and answers once the word
// read through the registered read port reaches the result registers. Traverse and
// search read one slot per cycle through the read port: traverse over n stored words
// gives n results on consecutive cycles after the first read. o_last marks the final
// result of each command. Actions 6 and 7 are ignored and give no result.
module linear_array_deque_with_search_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      i_action,
    input  logic signed [lads_pkg::DATA_W-1:0] i_value,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic signed [lads_pkg::DATA_W-1:0] o_data,
    output logic [2:0]                      o_slot,
    output logic                            o_last
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    localparam logic [lads_pkg::SLOT_W-1:0] LAST_SLOT = lads_pkg::SLOT_W'(lads_pkg::DEPTH - 1);
    localparam logic [lads_pkg::SLOT_W-1:0] ONE       = lads_pkg::SLOT_W'(1);

    logic [lads_pkg::DATA_W-1:0] mem [lads_pkg::DEPTH];

    t_state                          r_state;
    lads_pkg::t_action               r_op;
    logic [lads_pkg::SLOT_W-1:0]     r_front;
    logic [lads_pkg::SLOT_W-1:0]     r_rear;
    logic                            r_empty;
    logic [lads_pkg::SLOT_W-1:0]     r_ptr;
    logic signed [lads_pkg::DATA_W-1:0] r_value;
    logic signed [lads_pkg::DATA_W-1:0] r_rd_data;
    logic                            r_valid;
    lads_pkg::t_status               r_status;
    logic signed [lads_pkg::DATA_W-1:0] r_data;
    logic [2:0]                      r_slot;
    logic                            r_last;

    logic                            accept;
    logic                            wr_en;
    logic [lads_pkg::SLOT_W-1:0]     wr_addr;
    logic [lads_pkg::SLOT_W-1:0]     rd_addr;
    logic                            at_rear;

    assign accept  = start && (r_state == S_IDLE);
    assign at_rear = (r_ptr == r_rear);

    // write slot of a push
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        if (accept) begin
            if (i_action == lads_pkg::ACT_PUSH_REAR) begin
                wr_en   = r_empty || (r_rear != LAST_SLOT);
                wr_addr = r_empty ? '0 : r_rear + ONE;
            end else if (i_action == lads_pkg::ACT_PUSH_FRONT) begin
                wr_en   = r_empty || (r_front != '0);
                wr_addr = r_empty ? '0 : r_front - ONE;
            end
        end
    end

    always_comb begin
        if (r_state == S_WALK) begin
            rd_addr = r_ptr + ONE;
        end else if (i_action == lads_pkg::ACT_POP_REAR) begin
            rd_addr = r_rear;
        end else begin
            rd_addr = r_front;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= lads_pkg::t_action'(i_action);
                        r_value <= i_value;
                        r_last  <= 1'b1;
                        r_data  <= i_value;
                        r_slot  <= 3'd0;
                        unique case (i_action)
                            lads_pkg::ACT_PUSH_REAR, lads_pkg::ACT_PUSH_FRONT: begin
                                r_valid <= 1'b1;
                                if (wr_en) begin
                                    r_status <= lads_pkg::ST_OK;
                                    r_slot   <= lads_pkg::to_slot(wr_addr);
                                    r_empty  <= 1'b0;
                                    if (r_empty) begin
                                        r_front <= '0;
                                        r_rear  <= '0;
                                    end else if (i_action == lads_pkg::ACT_PUSH_REAR) begin
                                        r_rear <= wr_addr;
                                    end else begin
                                        r_front <= wr_addr;
                                    end
                                end else begin
                                    r_status <= lads_pkg::ST_OVERFLOW;
                                end
                            end
                            lads_pkg::ACT_POP_FRONT, lads_pkg::ACT_POP_REAR: begin
                                if (r_empty) begin
                                    r_valid  <= 1'b1;
                                    r_status <= lads_pkg::ST_UNDERFLOW;
                                    r_data   <= '0;
                                end else begin
                                    r_ptr   <= rd_addr;
                                    r_state <= S_WALK;
                                    if (r_front >= r_rear) begin
                                        r_front <= '0;
                                        r_rear  <= '0;
                                        r_empty <= 1'b1;
                                    end else if (i_action == lads_pkg::ACT_POP_FRONT) begin
                                        r_front <= r_front + ONE;
                                    end else begin
                                        r_rear <= r_rear - ONE;
                                    end
                                end
                            end
                            lads_pkg::ACT_TRAVERSE, lads_pkg::ACT_SEARCH: begin
                                if (r_empty) begin
                                    r_valid  <= 1'b1;
                                    r_status <= lads_pkg::ST_UNDERFLOW;
                                    if (i_action == lads_pkg::ACT_TRAVERSE) begin
                                        r_data <= '0;
                                    end
                                end else begin
                                    r_ptr   <= r_front;
                                    r_state <= S_WALK;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    r_status <= lads_pkg::ST_OK;
                    unique case (r_op)
                        lads_pkg::ACT_POP_FRONT, lads_pkg::ACT_POP_REAR: begin
                            r_valid <= 1'b1;
                            r_data  <= r_rd_data;
                            r_slot  <= lads_pkg::to_slot(r_ptr);
                            r_last  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        lads_pkg::ACT_TRAVERSE: begin
                            r_valid <= 1'b1;
                            r_data  <= r_rd_data;
                            r_slot  <= lads_pkg::to_slot(r_ptr);
                            r_last  <= at_rear;
                            if (at_rear) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_ptr <= r_ptr + ONE;
                            end
                        end
                        lads_pkg::ACT_SEARCH: begin
                            r_data <= r_value;
                            r_last <= 1'b1;
                            if (r_rd_data == r_value) begin
                                r_valid <= 1'b1;
                                r_slot  <= lads_pkg::to_slot(r_ptr);
                                r_state <= S_IDLE;
                            end else if (at_rear) begin
                                r_valid  <= 1'b1;
                                r_status <= lads_pkg::ST_NOTFOUND;
                                r_slot   <= 3'd0;
                                r_state  <= S_IDLE;
                            end else begin
                                r_ptr <= r_ptr + ONE;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state == S_WALK);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_slot   = r_slot;
    assign o_last   = r_last;

`ifndef SYNTHESIS
    // traverse results come on consecutive cycles
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("traverse result gap");

    // push answers in the next cycle and leaves the block free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == lads_pkg::ACT_PUSH_REAR
                    || i_action == lads_pkg::ACT_PUSH_FRONT))
        |=> (o_valid && o_last && !busy))
        else $error("push transfer not answered");

    // an empty store keeps both ends at slot zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_front == '0 && r_rear == '0))
        else $error("empty store with stray ends");

    // ends stay ordered while words are held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_empty |-> (r_front <= r_rear))
        else $error("front beyond rear");

    // only the final result may carry an error status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != lads_pkg::ST_OK) |-> o_last)
        else $error("error status on inner result");
`endif

endmodule
